// File: rtl/mfp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 step for the message frame parser.
// No dependencies; the classifier, parser and top-level files import this package.
package mfp_pkg;

	// Default queue depths: the front queue and the result queue
	localparam int unsigned InQueueDepth  = 4;
	localparam int unsigned OutQueueDepth = 2;

	// Frame marker characters
	localparam logic [7:0] ChStart  = 8'h24; // '$'
	localparam logic [7:0] ChV1     = 8'h4D; // 'M'
	localparam logic [7:0] ChV2     = 8'h58; // 'X'
	localparam logic [7:0] ChDirReq = 8'h3C; // '<'
	localparam logic [7:0] ChDirRsp = 8'h3E; // '>'
	localparam logic [7:0] ChDirErr = 8'h21; // '!'

	localparam logic [7:0] CrcPoly  = 8'hD5;
	localparam logic [7:0] ByteMask = 8'hFF;

	// Direction codes carried in the records
	localparam logic [1:0] DirReq = 2'd0;
	localparam logic [1:0] DirRsp = 2'd1;
	localparam logic [1:0] DirErr = 2'd2;

	// Version codes
	localparam logic [1:0] VerOne = 2'd1;
	localparam logic [1:0] VerTwo = 2'd2;

	// Record kinds
	localparam logic KindData = 1'b0;
	localparam logic KindEnd  = 1'b1;

	// Byte classes found by the front end
	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_START,
		CLS_V1,
		CLS_V2,
		CLS_DIR_REQ,
		CLS_DIR_RSP,
		CLS_DIR_ERR
	} byte_class_t;

	// One classified byte as it waits for the parser
	typedef struct packed {
		logic [7:0]  data;
		byte_class_t cls;
	} cls_item_t;

	// One result record
	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [1:0]  version;
		logic [1:0]  direction;
		logic [15:0] code;
		logic [15:0] size;
		logic        ok;
	} record_t;

	// CRC-8, MSB first, one byte per call
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = (crc ^ b) & ByteMask;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/mfp_queue.sv
`timescale 1ns / 1ps
// Small first-in first-out queue with a full/empty handshake on both sides.
// Depends on nothing but its parameters; used for the front and result queues.
module mfp_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCount = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == FullCount);
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store an accepted request
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCount)
		else $error("queue fill level beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && !pop_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("queue fill level did not rise on push");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && pop_ok |=> count_q == $past(count_q))
		else $error("queue fill level moved on push with pop");
`endif

endmodule

// File: rtl/mfp_classify.sv
`timescale 1ns / 1ps
// Front end: sorts each received byte into a marker class for the parser.
// Depends on mfp_pkg for the marker characters and the class type.
module mfp_classify import mfp_pkg::*; (
	input  logic [7:0] rx_byte,
	output cls_item_t  item
);

	// Decode the marker characters
	always_comb begin
		item.data = rx_byte;
		unique case (rx_byte)
			ChStart:  item.cls = CLS_START;
			ChV1:     item.cls = CLS_V1;
			ChV2:     item.cls = CLS_V2;
			ChDirReq: item.cls = CLS_DIR_REQ;
			ChDirRsp: item.cls = CLS_DIR_RSP;
			ChDirErr: item.cls = CLS_DIR_ERR;
			default:  item.cls = CLS_OTHER;
		endcase
	end

endmodule

// File: rtl/mfp_parser.sv
`timescale 1ns / 1ps
// Back end: frame state machine, XOR checksum and CRC-8, record building.
// Depends on mfp_pkg for the class and record types and crc8_update.
module mfp_parser import mfp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	input  cls_item_t item,
	output logic      item_pop,
	input  logic      rec_full,
	output logic      rec_push,
	output record_t   rec
);

	typedef enum logic [13:0] {
		PH_IDLE     = 14'b00000000000001,
		PH_PROTO    = 14'b00000000000010,
		PH_DIR      = 14'b00000000000100,
		PH_V1_LEN   = 14'b00000000001000,
		PH_V1_CODE  = 14'b00000000010000,
		PH_V1_DATA  = 14'b00000000100000,
		PH_V1_CHECK = 14'b00000001000000,
		PH_V2_FLAG  = 14'b00000010000000,
		PH_V2_CODEL = 14'b00000100000000,
		PH_V2_CODEH = 14'b00001000000000,
		PH_V2_LENL  = 14'b00010000000000,
		PH_V2_LENH  = 14'b00100000000000,
		PH_V2_DATA  = 14'b01000000000000,
		PH_V2_CHECK = 14'b10000000000000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic        v2_q, v2_n;
	logic [1:0]  dir_q, dir_n;
	logic [15:0] code_q, code_n;
	logic [15:0] size_q, size_n;
	logic [15:0] count_q, count_n;
	logic [7:0]  xor_q, xor_n;
	logic [7:0]  crc_q, crc_n;
	logic        fire;
	logic [7:0]  b;
	logic [7:0]  crc_step;
	logic [15:0] count_inc;
	logic [15:0] size_hi;

	// Take a byte only when a result slot is free
	assign fire      = item_valid && !rec_full;
	assign item_pop  = fire;
	assign b         = item.data;
	assign crc_step  = crc8_update(crc_q, b);
	assign count_inc = count_q + 16'd1;
	assign size_hi   = {b, size_q[7:0]};

	// Next state and record for the byte at the head of the queue
	always_comb begin
		phase_n  = phase_q;
		v2_n     = v2_q;
		dir_n    = dir_q;
		code_n   = code_q;
		size_n   = size_q;
		count_n  = count_q;
		xor_n    = xor_q;
		crc_n    = crc_q;
		rec_push = 1'b0;
		rec.kind       = KindData;
		rec.data_byte  = b;
		rec.byte_index = count_q;
		rec.version    = v2_q ? VerTwo : VerOne;
		rec.direction  = dir_q;
		rec.code       = code_q;
		rec.size       = size_q;
		rec.ok         = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.cls == CLS_START) begin
					phase_n = PH_PROTO;
				end
			end
			PH_PROTO: begin
				if (item.cls == CLS_V1) begin
					v2_n    = 1'b0;
					phase_n = PH_DIR;
				end else if (item.cls == CLS_V2) begin
					v2_n    = 1'b1;
					phase_n = PH_DIR;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_DIR: begin
				phase_n = v2_q ? PH_V2_FLAG : PH_V1_LEN;
				unique case (item.cls)
					CLS_DIR_REQ: dir_n = DirReq;
					CLS_DIR_RSP: dir_n = DirRsp;
					CLS_DIR_ERR: dir_n = DirErr;
					default:     phase_n = PH_IDLE;
				endcase
			end
			PH_V1_LEN: begin
				size_n  = {8'd0, b};
				xor_n   = b;
				count_n = '0;
				phase_n = PH_V1_CODE;
			end
			PH_V1_CODE: begin
				code_n  = {8'd0, b};
				xor_n   = xor_q ^ b;
				phase_n = (size_q == '0) ? PH_V1_CHECK : PH_V1_DATA;
			end
			PH_V1_DATA, PH_V2_DATA: begin
				rec_push = fire;
				if (phase_q == PH_V1_DATA) begin
					xor_n = xor_q ^ b;
				end else begin
					crc_n = crc_step;
				end
				count_n = count_inc;
				if (count_inc == size_q) begin
					phase_n = (phase_q == PH_V1_DATA) ? PH_V1_CHECK : PH_V2_CHECK;
				end
			end
			PH_V1_CHECK, PH_V2_CHECK: begin
				rec_push      = fire;
				rec.kind      = KindEnd;
				rec.data_byte = '0;
				rec.ok        = (phase_q == PH_V1_CHECK) ? (b == xor_q) : (b == crc_q);
				phase_n       = PH_IDLE;
			end
			PH_V2_FLAG: begin
				crc_n   = crc8_update(8'd0, b);
				phase_n = PH_V2_CODEL;
			end
			PH_V2_CODEL: begin
				code_n  = {8'd0, b};
				crc_n   = crc_step;
				phase_n = PH_V2_CODEH;
			end
			PH_V2_CODEH: begin
				code_n  = {b, code_q[7:0]};
				crc_n   = crc_step;
				phase_n = PH_V2_LENL;
			end
			PH_V2_LENL: begin
				size_n  = {8'd0, b};
				crc_n   = crc_step;
				phase_n = PH_V2_LENH;
			end
			PH_V2_LENH: begin
				size_n  = size_hi;
				crc_n   = crc_step;
				count_n = '0;
				phase_n = (size_hi == '0) ? PH_V2_CHECK : PH_V2_DATA;
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

	// Advance the frame state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			v2_q    <= 1'b0;
			dir_q   <= '0;
			code_q  <= '0;
			size_q  <= '0;
			count_q <= '0;
			xor_q   <= '0;
			crc_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			v2_q    <= v2_n;
			dir_q   <= dir_n;
			code_q  <= code_n;
			size_q  <= size_n;
			count_q <= count_n;
			xor_q   <= xor_n;
			crc_q   <= crc_n;
		end
	end

`ifndef SYNTHESIS
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rec_push && rec.kind == KindEnd |=> phase_q == PH_IDLE)
		else $error("parser did not return to idle after frame end");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && rec_push && rec.kind == KindData |=> count_q == $past(count_q) + 16'd1)
		else $error("payload count did not advance on a payload byte");
	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push && fire |-> !rec_full)
		else $error("record pushed into a full result queue");
	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> phase_q == $past(phase_q) && count_q == $past(count_q))
		else $error("parser state moved without a consumed byte");
`endif

endmodule

// File: rtl/msp_frame_parser.sv
`timescale 1ns / 1ps
// Frame parser top level: classifier, front queue, parser, result queue.
// Path: front queue, parser, result queue; a record is on the ports while empty is low.
// Throughput: one byte per cycle while results are popped; the parser takes a byte
// from the front queue whenever the result queue has a free slot.
// Reset: arst_n clears both queues and returns the parser to idle at once.
// Depends on mfp_pkg, mfp_classify, mfp_queue and mfp_parser.
module msp_frame_parser import mfp_pkg::*; #(
	parameter int unsigned IN_DEPTH  = InQueueDepth,
	parameter int unsigned OUT_DEPTH = OutQueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        record_kind,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index,
	output logic [1:0]  frame_version,
	output logic [1:0]  frame_direction,
	output logic [15:0] message_code,
	output logic [15:0] payload_size,
	output logic        check_ok
);

	cls_item_t in_item;
	cls_item_t head_item;
	logic      head_empty;
	logic      head_pop;
	logic      rec_full;
	logic      rec_push;
	record_t   rec_in;
	record_t   rec_out;

	// Classify the incoming byte
	mfp_classify u_classify (
		.rx_byte (rx_byte),
		.item    (in_item)
	);

	// Hold classified bytes between front and back
	mfp_queue #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (IN_DEPTH)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_item),
		.full   (full),
		.pop    (head_pop),
		.rdata  (head_item),
		.empty  (head_empty)
	);

	// Parse frames
	mfp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!head_empty),
		.item       (head_item),
		.item_pop   (head_pop),
		.rec_full   (rec_full),
		.rec_push   (rec_push),
		.rec        (rec_in)
	);

	// Hold finished records for the consumer
	mfp_queue #(
		.WIDTH ($bits(record_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.full   (rec_full),
		.pop    (pop),
		.rdata  (rec_out),
		.empty  (empty)
	);

	assign record_kind     = rec_out.kind;
	assign data_byte       = rec_out.data_byte;
	assign byte_index      = rec_out.byte_index;
	assign frame_version   = rec_out.version;
	assign frame_direction = rec_out.direction;
	assign message_code    = rec_out.code;
	assign payload_size    = rec_out.size;
	assign check_ok        = rec_out.ok;

endmodule
